/* rtl/ris_pkg.sv */
// Shared types, constants and helper functions for the reserved identifier scanner.
package ris_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 6;

    localparam int OUT_OFFSET_W  = 32;
    localparam int OUT_LENGTH_W  = 6;
    localparam int RES_DATA_W    = OUT_OFFSET_W + OUT_LENGTH_W + 1;
    localparam int M_TDATA_W     = ((RES_DATA_W + 7) / 8) * 8;
    localparam int ALL_CLEAN_BIT = OUT_OFFSET_W + OUT_LENGTH_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int NUM_EXC     = 15;
    localparam int EXC_MAX_LEN = 19;
    localparam int EXC_POS_W   = 5;

    typedef logic [NUM_EXC-1:0] exc_mask_t;

    // names are right-justified: first character sits highest
    localparam logic [8*EXC_MAX_LEN-1:0] EXC_TEXT [NUM_EXC] = '{
        "__attribute__", "__bool__", "__bool", "__DATE__", "__FILE__",
        "__func__", "__FUNC__", "__function__", "__FUNCTION__", "__inline__",
        "__inline", "__LINE__", {"__PRETTY_", "FUNCTION__"}, "__TIME__",
        "__TIMESTAMP__"
    };

    localparam logic [EXC_POS_W-1:0] EXC_LEN [NUM_EXC] = '{
        5'd13, 5'd8, 5'd6, 5'd8, 5'd8, 5'd8, 5'd8, 5'd12, 5'd12, 5'd10,
        5'd8, 5'd8, 5'd19, 5'd8, 5'd13
    };

    typedef enum logic [3:0] {
        MODE_NORMAL,
        MODE_IDENT,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_CHAR,
        MODE_CHAR_ESC,
        MODE_STR,
        MODE_STR_ESC
    } scan_mode_t;

    localparam logic KIND_RESERVED = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic                    kind;
        logic [OUT_OFFSET_W-1:0] start_offset;
        logic [OUT_LENGTH_W-1:0] name_length;
        logic                    all_clean;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_ident(input logic [7:0] b);
        return b inside {["A":"Z"], ["a":"z"], ["0":"9"], "$", "_"};
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return b inside {["A":"Z"]};
    endfunction

    // character of exception name k at position pos (pos below its length)
    function automatic logic [7:0] exc_byte(input int k, input logic [EXC_POS_W-1:0] pos);
        logic [EXC_POS_W-1:0]     idx;
        logic [8*EXC_MAX_LEN-1:0] tmp;
        idx = EXC_LEN[k] - 5'd1 - pos;
        tmp = EXC_TEXT[k] >> {idx, 3'b000};
        return tmp[7:0];
    endfunction

endpackage

/* rtl/ris_in_reg.sv */
// Input register stage: holds one accepted item until the scan core takes it.
module ris_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    input  logic              take,
    output ris_pkg::in_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       eot_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    assign item.valid       = valid_reg;
    assign item.text_byte   = byte_reg;
    assign item.end_of_text = eot_reg;

endmodule

/* rtl/ris_core.sv */
// Scan core: lexer mode, identifier run tracking, exception mask and result forming.
module ris_core #(
    parameter int OFFSET_BITS = ris_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = ris_pkg::LENGTH_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ris_pkg::in_item_t item,
    input  logic              take,
    output ris_pkg::push_t    push
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    ris_pkg::scan_mode_t      mode_reg,        mode_next;
    logic [OFFSET_BITS-1:0]   byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0]   run_start_reg,   run_start_next;
    logic [LENGTH_BITS-1:0]   run_length_reg,  run_length_next;
    logic                     prev_us_reg,     prev_us_next;
    logic                     dbl_us_reg,      dbl_us_next;
    logic                     lead_up_reg,     lead_up_next;
    ris_pkg::exc_mask_t       mask_reg,        mask_next;
    logic                     clean_reg,       clean_next;

    logic [7:0]               b;
    logic                     id;
    logic                     cont;
    logic                     exc_hit;
    logic                     reserved;
    logic                     do_nb;
    ris_pkg::exc_mask_t       step_in;
    ris_pkg::exc_mask_t       step_mask;
    logic [LENGTH_BITS-1:0]   step_pos;
    ris_pkg::result_t         res_reserved;
    ris_pkg::result_t         res_summary;

    assign b    = item.text_byte;
    assign id   = ris_pkg::is_ident(b);
    assign cont = (mode_reg == ris_pkg::MODE_IDENT) && id;

    // candidate mask step: continuing run or first byte of a new one
    assign step_in  = cont ? mask_reg : '1;
    assign step_pos = cont ? run_length_reg : '0;

    always_comb
    begin
        for (int k = 0; k < ris_pkg::NUM_EXC; k++)
        begin
            step_mask[k] = step_in[k]
                && (step_pos < LENGTH_BITS'(ris_pkg::EXC_LEN[k]))
                && (ris_pkg::exc_byte(k, step_pos[ris_pkg::EXC_POS_W-1:0]) == b);
        end
    end

    always_comb
    begin
        exc_hit = 1'b0;
        for (int k = 0; k < ris_pkg::NUM_EXC; k++)
        begin
            if (mask_reg[k] && (run_length_reg == LENGTH_BITS'(ris_pkg::EXC_LEN[k])))
            begin
                exc_hit = 1'b1;
            end
        end
    end

    assign reserved = !exc_hit && (dbl_us_reg || lead_up_reg);

    // next state
    always_comb
    begin
        mode_next        = mode_reg;
        byte_offset_next = byte_offset_reg;
        run_start_next   = run_start_reg;
        run_length_next  = run_length_reg;
        prev_us_next     = prev_us_reg;
        dbl_us_next      = dbl_us_reg;
        lead_up_next     = lead_up_reg;
        mask_next        = mask_reg;
        clean_next       = clean_reg;
        do_nb            = 1'b0;

        if (take && item.end_of_text)
        begin
            mode_next        = ris_pkg::MODE_NORMAL;
            byte_offset_next = '0;
            run_start_next   = '0;
            run_length_next  = '0;
            prev_us_next     = 1'b0;
            dbl_us_next      = 1'b0;
            lead_up_next     = 1'b0;
            mask_next        = '1;
            clean_next       = 1'b1;
        end
        else if (take)
        begin
            byte_offset_next = byte_offset_reg + OFFSET_BITS'(1);
            case (mode_reg)
                ris_pkg::MODE_IDENT:
                begin
                    if (id)
                    begin
                        if (prev_us_reg && b == "_")
                        begin
                            dbl_us_next = 1'b1;
                        end
                        if (run_length_reg == LENGTH_BITS'(1) && prev_us_reg
                            && ris_pkg::is_upper(b))
                        begin
                            lead_up_next = 1'b1;
                        end
                        mask_next = step_mask;
                        if (run_length_reg != LEN_MAX)
                        begin
                            run_length_next = run_length_reg + LENGTH_BITS'(1);
                        end
                        prev_us_next = (b == "_");
                    end
                    else
                    begin
                        if (reserved)
                        begin
                            clean_next = 1'b0;
                        end
                        do_nb = 1'b1;
                    end
                end
                ris_pkg::MODE_SLASH:
                begin
                    if (b == "/")
                    begin
                        mode_next = ris_pkg::MODE_LINE;
                    end
                    else if (b == "*")
                    begin
                        mode_next = ris_pkg::MODE_BLOCK;
                    end
                    else
                    begin
                        do_nb = 1'b1;
                    end
                end
                ris_pkg::MODE_LINE:
                begin
                    if (b == "\n")
                    begin
                        mode_next = ris_pkg::MODE_NORMAL;
                    end
                end
                ris_pkg::MODE_BLOCK:
                begin
                    if (b == "*")
                    begin
                        mode_next = ris_pkg::MODE_BLOCK_STAR;
                    end
                end
                ris_pkg::MODE_BLOCK_STAR:
                begin
                    if (b == "/")
                    begin
                        mode_next = ris_pkg::MODE_NORMAL;
                    end
                    else if (b != "*")
                    begin
                        mode_next = ris_pkg::MODE_BLOCK;
                    end
                end
                ris_pkg::MODE_CHAR:
                begin
                    if (b == "\\")
                    begin
                        mode_next = ris_pkg::MODE_CHAR_ESC;
                    end
                    else if (b == "'")
                    begin
                        mode_next = ris_pkg::MODE_NORMAL;
                    end
                end
                ris_pkg::MODE_CHAR_ESC:
                begin
                    mode_next = ris_pkg::MODE_CHAR;
                end
                ris_pkg::MODE_STR:
                begin
                    if (b == "\\")
                    begin
                        mode_next = ris_pkg::MODE_STR_ESC;
                    end
                    else if (b == "\"")
                    begin
                        mode_next = ris_pkg::MODE_NORMAL;
                    end
                end
                ris_pkg::MODE_STR_ESC:
                begin
                    mode_next = ris_pkg::MODE_STR;
                end
                default:
                begin
                    do_nb = 1'b1;
                end
            endcase

            // byte seen as ordinary code
            if (do_nb)
            begin
                if (id)
                begin
                    mode_next       = ris_pkg::MODE_IDENT;
                    run_start_next  = byte_offset_reg;
                    run_length_next = LENGTH_BITS'(1);
                    prev_us_next    = (b == "_");
                    dbl_us_next     = 1'b0;
                    lead_up_next    = 1'b0;
                    mask_next       = step_mask;
                end
                else if (b == "/")
                begin
                    mode_next = ris_pkg::MODE_SLASH;
                end
                else if (b == "'")
                begin
                    mode_next = ris_pkg::MODE_CHAR;
                end
                else if (b == "\"")
                begin
                    mode_next = ris_pkg::MODE_STR;
                end
                else
                begin
                    mode_next = ris_pkg::MODE_NORMAL;
                end
            end
        end
    end

    // result forming
    always_comb
    begin
        res_reserved.kind         = ris_pkg::KIND_RESERVED;
        res_reserved.start_offset = ris_pkg::OUT_OFFSET_W'(run_start_reg);
        res_reserved.name_length  = ris_pkg::OUT_LENGTH_W'(run_length_reg);
        res_reserved.all_clean    = 1'b0;
        res_reserved.last         = 1'b1;

        res_summary.kind          = ris_pkg::KIND_SUMMARY;
        res_summary.start_offset  = '0;
        res_summary.name_length   = '0;
        res_summary.all_clean     = clean_reg;
        res_summary.last          = 1'b1;

        push.count  = 2'd0;
        push.first  = res_reserved;
        push.second = res_summary;

        if (take && item.end_of_text)
        begin
            if (mode_reg == ris_pkg::MODE_IDENT && reserved)
            begin
                push.count                 = 2'd2;
                push.first.last            = 1'b0;
                push.second.all_clean      = 1'b0;
            end
            else
            begin
                push.count = 2'd1;
                push.first = res_summary;
            end
        end
        else if (take && mode_reg == ris_pkg::MODE_IDENT && !id && reserved)
        begin
            push.count = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= ris_pkg::MODE_NORMAL;
            byte_offset_reg <= '0;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            prev_us_reg     <= 1'b0;
            dbl_us_reg      <= 1'b0;
            lead_up_reg     <= 1'b0;
            mask_reg        <= '1;
            clean_reg       <= 1'b1;
        end
        else
        begin
            mode_reg        <= mode_next;
            byte_offset_reg <= byte_offset_next;
            run_start_reg   <= run_start_next;
            run_length_reg  <= run_length_next;
            prev_us_reg     <= prev_us_next;
            dbl_us_reg      <= dbl_us_next;
            lead_up_reg     <= lead_up_next;
            mask_reg        <= mask_next;
            clean_reg       <= clean_next;
        end
    end

endmodule

/* rtl/ris_out_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
module ris_out_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  ris_pkg::push_t   push,
    output logic             room2,
    output logic             out_valid,
    input  logic             out_ready,
    output ris_pkg::result_t out_item
);

    localparam int PTR_W = ris_pkg::FIFO_PTR_W;

    ris_pkg::result_t mem_reg [ris_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room2     = (count_reg <= (PTR_W+1)'(ris_pkg::FIFO_DEPTH - 2));

    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

/* rtl/reserved_identifier_scanner.sv */
// Top level of the reserved identifier scanner.
//
// Slave channel: one source byte per item in s_tdata; s_tuser set marks end
// of text and the byte is then ignored. Master channel: one result per item,
// kind in m_tuser (reserved name or end-of-text summary), tlast on the final
// result that an input item causes.
// An accepted item waits in the input register until the core takes it; its
// results go into the result queue. Throughput is one input item per cycle
// while that queue has room for two results; a byte gives at most one result,
// an end-of-text item one or two, which the master side drains one per cycle
// while m_tready is high. The input register takes a new item while the
// scanned one moves into a four-entry result queue; input stalls only while
// that queue lacks room for two results, i.e. when the receiver holds m_tready low.
// Reset puts the scanner in plain code mode at offset zero with the clean
// flag set and empties both the input register and the result queue.
// After an end-of-text summary the scan core returns to that mode, offset and flag state.
module reserved_identifier_scanner #(
    parameter int OFFSET_BITS = ris_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = ris_pkg::LENGTH_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // text_byte
    input  logic                          s_tuser,   // end_of_text
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ris_pkg::M_TDATA_W-1:0] m_tdata,   // start_offset, name_length, all_clean
    output logic                          m_tuser,   // kind
    output logic                          m_tlast
);

    ris_pkg::in_item_t item;
    ris_pkg::push_t    push;
    ris_pkg::result_t  res;
    logic              room2;
    logic              take;

    assign take = item.valid && room2;

    ris_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .text_byte   (s_tdata),
        .end_of_text (s_tuser),
        .take        (take),
        .item        (item)
    );

    ris_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .push  (push)
    );

    ris_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (res)
    );

    assign m_tdata = {{(ris_pkg::M_TDATA_W - ris_pkg::RES_DATA_W){1'b0}},
                      res.all_clean, res.name_length, res.start_offset};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

/* rtl/ris_checker.sv */
// Port-level checker for the reserved identifier scanner, with its bind.
module ris_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ris_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input back-pressure only with results waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a fresh result comes from an input item that went through the input register
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a matching input item");

    // only a reserved name can precede a summary within one item
    a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tuser == ris_pkg::KIND_RESERVED)
                                 && !m_tdata[ris_pkg::ALL_CLEAN_BIT])
        else $error("bad non-final result");

endmodule

bind reserved_identifier_scanner ris_checker u_ris_checker (.*);
